// ----- design/aalr_pkg.sv -----
// Shared constants, command and status types and helper functions of the line rasterizer.
`timescale 1ns / 1ps

package aalr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int FRAME_BITS = 12;
  localparam int COLOR_BITS = 24;
  localparam int COV_BITS   = 8;

  localparam int PIX_W  = COORD_BITS + 1;
  localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int CMP_W  = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;

  localparam int IN_DATA_W  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * PIX_W + COV_BITS + COLOR_BITS;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  localparam logic [COV_BITS-1:0] COV_MAX = 8'd255;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 12'd800;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 12'd600;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic load_start;
    logic setup;
    logic div_step;
    logic load_pair;
    logic sel_hi;
  } cmd_t;

  typedef struct packed {
    logic step_done;
  } sts_t;

  // Magnitude of a difference of two coordinates; always fits COORD_BITS.
  function automatic logic [COORD_BITS-1:0] mag(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] n;
    n = v[PIX_W-1] ? (~v + PIX_W'(1)) : v;
    return n[COORD_BITS-1:0];
  endfunction

  // trunc(255 * v / 2^FRAC_BITS) for v in [0, 2^FRAC_BITS].
  function automatic logic [COV_BITS-1:0] cov_of(input logic [FRAC_BITS:0] v);
    logic [FRAC_BITS+COV_BITS:0] p;
    p = (FRAC_BITS + COV_BITS + 1)'(v) * (FRAC_BITS + COV_BITS + 1)'(COV_MAX);
    return p[FRAC_BITS+COV_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic in_range(input logic [PIX_W-1:0] p,
                                    input logic [FRAME_BITS-1:0] lim);
    return !p[PIX_W-1] && (CMP_W'(p[PIX_W-2:0]) < CMP_W'(lim));
  endfunction

endpackage

// ----- design/antialiased_line_rasterizer_core.sv -----
// Top level of the antialiased line rasterizer: ports, word packing and assertions.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tdata: start and end points, colour; tuser: operation
// out_     master     out_tvalid/out_tready tdata: pixel, coverage, colour; tuser: flags; tlast
// cfg_     write      cfg_we               cfg_index selects frame width or height
//
// A step word is accepted and its pixel pair snapshot, then each of the two output words is
// held until the sink takes it. A start word is transposed, its endpoints are ordered, and
// the restoring slope divider then runs, which yields one quotient bit per cycle. Reset is
// synchronous and active low; it returns the block to idle with no line active and loads the
// frame size to 800 by 600. in_tready is high only while idle, so a stalled output holds the
// whole block.
module antialiased_line_rasterizer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y, [71:48] line_color
  input  logic [aalr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [12:0] pixel_x, [25:13] pixel_y, [33:26] coverage, [57:34] pixel_color, rest zero
  output logic [aalr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] in_frame, [1] pair_last
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [aalr_pkg::FRAME_BITS-1:0]     cfg_wdata
);

  localparam int CB = aalr_pkg::COORD_BITS;

  aalr_pkg::cmd_t cmd;
  aalr_pkg::sts_t sts;

  logic [aalr_pkg::PIX_W-1:0]      pixel_x, pixel_y;
  logic [aalr_pkg::COV_BITS-1:0]   coverage;
  logic [aalr_pkg::COLOR_BITS-1:0] pixel_color;
  logic                            in_frame, pair_last, line_done;

  aalr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aalr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (in_tdata[CB-1:0]),
    .start_y     (in_tdata[2*CB-1:CB]),
    .end_x       (in_tdata[3*CB-1:2*CB]),
    .end_y       (in_tdata[4*CB-1:3*CB]),
    .line_color  (in_tdata[4*CB+aalr_pkg::COLOR_BITS-1:4*CB]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .coverage    (coverage),
    .pixel_color (pixel_color),
    .in_frame    (in_frame),
    .pair_last   (pair_last),
    .line_done   (line_done)
  );

  // Output word packing, first field in the lowest bits.
  assign out_tdata = aalr_pkg::OUT_TDATA_W'({pixel_color, coverage, pixel_y, pixel_x});
  assign out_tuser = {pair_last, in_frame};
  assign out_tlast = line_done;

  // The block never takes a new word while a result is on offer.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while an output word is pending");

  // The end of a line can only be flagged on the second pixel of a pair.
  a_done_on_second : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("line end flagged on the first pixel of a pair");

  // A snapshot step is followed by the first pixel of its pair.
  a_pair_starts : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_pair |=> out_tvalid && !out_tuser[1])
    else $error("step did not present its first pixel");

  // Once the second pixel is taken the block is idle again.
  a_back_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[1] |=> in_tready && !out_tvalid)
    else $error("block did not return to idle after a pixel pair");

endmodule

// ----- design/aalr_ctrl.sv -----
// Controller state machine of the line rasterizer: sequencing of setup, division and pixel pairs.
`timescale 1ns / 1ps

module aalr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_op,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  aalr_pkg::sts_t sts,
  output aalr_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ORDER = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LO    = 3'd3;
  localparam logic [2:0] S_HI    = 3'd4;

  localparam logic [aalr_pkg::CNT_W-1:0] DIV_LAST = aalr_pkg::CNT_W'(aalr_pkg::Q_W - 1);

  logic [2:0]                 state_r, state_nxt;
  logic                       active_r, active_nxt;
  logic [aalr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          if (in_op == aalr_pkg::OP_START) begin
            cmd.load_start = 1'b1;
            active_nxt     = 1'b1;
            state_nxt      = S_ORDER;
          end else if (active_r) begin
            cmd.load_pair = 1'b1;
            if (sts.step_done) begin
              active_nxt = 1'b0;
            end
            state_nxt = S_LO;
          end
        end
      end
      S_ORDER: begin
        cmd.setup = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_LO: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        out_tvalid = 1'b1;
        cmd.sel_hi = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/aalr_datapath.sv -----
// Datapath of the line rasterizer: endpoint setup, slope divider, minor accumulator and pixel pair.
`timescale 1ns / 1ps

module aalr_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  aalr_pkg::cmd_t                         cmd,
  output aalr_pkg::sts_t                         sts,
  input  logic [aalr_pkg::COORD_BITS-1:0]        start_x,
  input  logic [aalr_pkg::COORD_BITS-1:0]        start_y,
  input  logic [aalr_pkg::COORD_BITS-1:0]        end_x,
  input  logic [aalr_pkg::COORD_BITS-1:0]        end_y,
  input  logic [aalr_pkg::COLOR_BITS-1:0]        line_color,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [aalr_pkg::FRAME_BITS-1:0]        cfg_wdata,
  output logic [aalr_pkg::PIX_W-1:0]             pixel_x,
  output logic [aalr_pkg::PIX_W-1:0]             pixel_y,
  output logic [aalr_pkg::COV_BITS-1:0]          coverage,
  output logic [aalr_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                   in_frame,
  output logic                                   pair_last,
  output logic                                   line_done
);

  localparam int CB = aalr_pkg::COORD_BITS;
  localparam int FB = aalr_pkg::FRAC_BITS;
  localparam int PW = aalr_pkg::PIX_W;
  localparam int AW = aalr_pkg::ACC_W;
  localparam int QW = aalr_pkg::Q_W;

  logic [aalr_pkg::FRAME_BITS-1:0] width_r, height_r;

  // Transposed endpoints: a is the major axis, b the minor.
  logic                  steep_r;
  logic [CB-1:0]         a0_r, b0_r, a1_r, b1_r;
  logic [aalr_pkg::COLOR_BITS-1:0] color_r;
  logic [PW-1:0]         major_r, major_nxt;
  logic [CB-1:0]         major_end_r;
  logic [AW-1:0]         accum_r, accum_nxt;
  logic [CB-1:0]         dx_r;
  logic [PW-1:0]         rem_r;
  logic [QW-1:0]         q_r;
  logic                  neg_r;

  logic [PW-1:0]         px_lo_r, py_lo_r, px_hi_r, py_hi_r;
  logic [aalr_pkg::COV_BITS-1:0] cov_lo_r, cov_hi_r;
  logic                  in_lo_r, in_hi_r, done_r;

  // Start word: steep test and transposition.
  logic [PW-1:0] raw_dx, raw_dy;
  logic          steep;
  always_comb begin
    raw_dx = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
    raw_dy = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
    steep  = aalr_pkg::mag(raw_dy) > aalr_pkg::mag(raw_dx);
  end

  // Ordering and divider set-up.
  logic [PW-1:0] d_maj, d_min;
  logic          swap, dx_zero, neg;
  logic [CB-1:0] maj_first, min_first, maj_last;
  always_comb begin
    d_maj     = {a1_r[CB-1], a1_r} - {a0_r[CB-1], a0_r};
    d_min     = {b1_r[CB-1], b1_r} - {b0_r[CB-1], b0_r};
    swap      = d_maj[PW-1];
    dx_zero   = (d_maj == '0);
    neg       = swap ? (!d_min[PW-1] && (d_min != '0)) : d_min[PW-1];
    maj_first = swap ? a1_r : a0_r;
    maj_last  = swap ? a0_r : a1_r;
    min_first = swap ? b1_r : b0_r;
  end

  // One quotient bit per cycle; the remainder left after each subtraction stays below the divisor.
  logic          ge;
  logic [PW-1:0] rem_sub;
  always_comb begin
    ge      = rem_r >= {1'b0, dx_r};
    rem_sub = ge ? (rem_r - {1'b0, dx_r}) : rem_r;
  end

  // Step: pixel pair from the running minor coordinate.
  logic [PW-1:0]  lo, hi;
  logic [FB-1:0]  frac;
  logic [AW-1:0]  slope_ext;
  logic [PW-1:0]  pxl, pyl, pxh, pyh;
  always_comb begin
    lo        = accum_r[FB+PW-1:FB];
    hi        = lo + PW'(1);
    frac      = accum_r[FB-1:0];
    sts.step_done = $signed(major_r) >= $signed({major_end_r[CB-1], major_end_r});
    slope_ext = {{(AW-QW){1'b0}}, q_r};
    pxl       = steep_r ? lo : major_r;
    pyl       = steep_r ? major_r : lo;
    pxh       = steep_r ? hi : major_r;
    pyh       = steep_r ? major_r : hi;
    major_nxt = major_r + PW'(1);
    accum_nxt = neg_r ? (accum_r - slope_ext) : (accum_r + slope_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= aalr_pkg::FRAME_WIDTH_RST;
      height_r <= aalr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == aalr_pkg::CFG_FRAME_WIDTH) begin
        width_r <= cfg_wdata;
      end else begin
        height_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      steep_r <= steep;
      a0_r    <= steep ? start_y : start_x;
      b0_r    <= steep ? start_x : start_y;
      a1_r    <= steep ? end_y : end_x;
      b1_r    <= steep ? end_x : end_y;
      color_r <= line_color;
    end
    if (cmd.setup) begin
      major_r     <= {maj_first[CB-1], maj_first};
      major_end_r <= maj_last;
      accum_r     <= {{(AW-FB-CB){min_first[CB-1]}}, min_first, {FB{1'b0}}};
      neg_r       <= neg;
      q_r         <= '0;
      // Both endpoints equal: dividing one by one gives the slope 1.0.
      dx_r        <= dx_zero ? CB'(1) : aalr_pkg::mag(d_maj);
      rem_r       <= dx_zero ? PW'(1) : {1'b0, aalr_pkg::mag(d_min)};
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[QW-2:0], ge};
      rem_r <= {rem_sub[CB-1:0], 1'b0};
    end
    if (cmd.load_pair) begin
      px_lo_r  <= pxl;
      py_lo_r  <= pyl;
      px_hi_r  <= pxh;
      py_hi_r  <= pyh;
      cov_lo_r <= aalr_pkg::cov_of(((FB+1)'(1) << FB) - {1'b0, frac});
      cov_hi_r <= aalr_pkg::cov_of({1'b0, frac});
      in_lo_r  <= aalr_pkg::in_range(pxl, width_r) && aalr_pkg::in_range(pyl, height_r);
      in_hi_r  <= aalr_pkg::in_range(pxh, width_r) && aalr_pkg::in_range(pyh, height_r);
      done_r   <= sts.step_done;
      if (!sts.step_done) begin
        major_r <= major_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  assign pixel_x     = cmd.sel_hi ? px_hi_r : px_lo_r;
  assign pixel_y     = cmd.sel_hi ? py_hi_r : py_lo_r;
  assign coverage    = cmd.sel_hi ? cov_hi_r : cov_lo_r;
  assign in_frame    = cmd.sel_hi ? in_hi_r : in_lo_r;
  assign pixel_color = color_r;
  assign pair_last   = cmd.sel_hi;
  assign line_done   = cmd.sel_hi && done_r;

endmodule

// ----- tb/aalr_pixel_checker.sv -----
// Checker for the line rasterizer: predicts the pixel words from the accepted input words.
`timescale 1ns / 1ps

module aalr_pixel_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [aalr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [aalr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [1:0]                          out_tuser,
  input  logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [aalr_pkg::FRAME_BITS-1:0]     cfg_wdata,
  output int                                  error_count,
  output int                                  pending_count
);

  import aalr_pkg::*;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COV_BITS-1:0]     cov;
    logic [COLOR_BITS-1:0]   colour;
    logic                    in_frame;
    logic                    pair_last;
    logic                    line_done;
  } pixel_write_t;

  pixel_write_t pixel_writes_due[$];
  pixel_write_t got, want;
  int           fail_tally;

  // Predicted state of the block.
  logic [FRAME_BITS-1:0] frame_w, frame_h;
  logic                  line_live;
  logic                  transposed;
  longint                major_at, major_stop, minor_acc, gradient;
  logic [COLOR_BITS-1:0] line_colour;

  assign error_count = fail_tally;

  function automatic longint abs_len(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic pixel_write_t make_pixel(input longint px, input longint py,
                                              input longint cov, input logic last,
                                              input logic done);
    pixel_write_t p;
    p.x         = px[PIX_W-1:0];
    p.y         = py[PIX_W-1:0];
    p.cov       = cov[COV_BITS-1:0];
    p.colour    = line_colour;
    p.in_frame  = (px >= 0) && (py >= 0) && (px < longint'(frame_w)) &&
                  (py < longint'(frame_h));
    p.pair_last = last;
    p.line_done = done;
    return p;
  endfunction

  task automatic load_line(input logic [IN_TDATA_W-1:0] d);
    longint ax, ay, bx, by, t, dx, dy, q;
    logic   steep;
    ax = longint'($signed(d[COORD_BITS-1:0]));
    ay = longint'($signed(d[2*COORD_BITS-1:COORD_BITS]));
    bx = longint'($signed(d[3*COORD_BITS-1:2*COORD_BITS]));
    by = longint'($signed(d[4*COORD_BITS-1:3*COORD_BITS]));
    steep = abs_len(by - ay) > abs_len(bx - ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    // A single point gets a unit gradient; otherwise the quotient truncates towards zero.
    if (dx == 0) begin
      gradient = longint'(1) << FRAC_BITS;
    end else begin
      q = (abs_len(dy) << FRAC_BITS) / dx;
      gradient = (dy < 0) ? -q : q;
    end
    transposed  = steep;
    major_at    = ax;
    major_stop  = bx;
    minor_acc   = ay * (longint'(1) << FRAC_BITS);
    line_colour = d[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    line_live   = 1'b1;
  endtask

  task automatic step_line();
    longint one, f, lo, cov_lo, cov_hi;
    logic   done;
    one    = longint'(1) << FRAC_BITS;
    f      = minor_acc & (one - 1);
    lo     = (minor_acc - f) >>> FRAC_BITS;
    cov_lo = (255 * (one - f)) >>> FRAC_BITS;
    cov_hi = (255 * f) >>> FRAC_BITS;
    done   = major_at >= major_stop;
    if (transposed) begin
      pixel_writes_due.push_back(make_pixel(lo, major_at, cov_lo, 1'b0, 1'b0));
      pixel_writes_due.push_back(make_pixel(lo + 1, major_at, cov_hi, 1'b1, done));
    end else begin
      pixel_writes_due.push_back(make_pixel(major_at, lo, cov_lo, 1'b0, 1'b0));
      pixel_writes_due.push_back(make_pixel(major_at, lo + 1, cov_hi, 1'b1, done));
    end
    if (done) begin
      line_live = 1'b0;
    end else begin
      major_at  = major_at + 1;
      minor_acc = minor_acc + gradient;
    end
  endtask

  initial begin
    fail_tally = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_w     = FRAME_WIDTH_RST;
      frame_h     = FRAME_HEIGHT_RST;
      line_live   = 1'b0;
      transposed  = 1'b0;
      major_at    = 0;
      major_stop  = 0;
      minor_acc   = 0;
      gradient    = 0;
      line_colour = '0;
      pixel_writes_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) frame_w = cfg_wdata;
        else frame_h = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_START) load_line(in_tdata);
        else if (line_live) step_line();
      end
      if (out_tvalid && out_tready) begin
        got.x         = out_tdata[PIX_W-1:0];
        got.y         = out_tdata[2*PIX_W-1:PIX_W];
        got.cov       = out_tdata[2*PIX_W+COV_BITS-1:2*PIX_W];
        got.colour    = out_tdata[2*PIX_W+COV_BITS+COLOR_BITS-1:2*PIX_W+COV_BITS];
        got.in_frame  = out_tuser[0];
        got.pair_last = out_tuser[1];
        got.line_done = out_tlast;
        if (pixel_writes_due.size() == 0) begin
          if (fail_tally < 10)
            $display("%0t: pixel word x=%0d y=%0d with nothing expected", $realtime,
                     got.x, got.y);
          fail_tally++;
        end else begin
          want = pixel_writes_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.cov !== want.cov ||
              got.colour !== want.colour || got.in_frame !== want.in_frame ||
              got.pair_last !== want.pair_last || got.line_done !== want.line_done) begin
            if (fail_tally < 10) begin
              $display("%0t: pixel word mismatch", $realtime);
              $display("  expected x=%0d y=%0d cov=%0d colour=%06h frame=%0b last=%0b done=%0b",
                       want.x, want.y, want.cov, want.colour, want.in_frame,
                       want.pair_last, want.line_done);
              $display("  actual   x=%0d y=%0d cov=%0d colour=%06h frame=%0b last=%0b done=%0b",
                       got.x, got.y, got.cov, got.colour, got.in_frame,
                       got.pair_last, got.line_done);
            end
            fail_tally++;
          end
        end
      end
    end
    pending_count <= pixel_writes_due.size();
  end

endmodule

// ----- tb/antialiased_line_rasterizer_core_test.sv -----
// Testbench top for the line rasterizer: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module antialiased_line_rasterizer_core_test;

  import aalr_pkg::*;

  // Roughly 1750 counted words in all: about twenty directed ones, the rest over six phases.
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 290;
  // Cap on the steps sent for one line, bar an extra step or two; longer lines are cut short by the next start.
  localparam int MAX_STEPS       = 40;
  // Length of the single long hold-off on the output, used to back the block up.
  localparam int HOLD_CYCLES     = 400;
  // A start word keeps the block busy through its slope division with no output to show for
  // it, so this many quiet cycles are allowed before touching the frame registers.
  localparam int SETTLE_CYCLES   = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [FRAME_BITS-1:0]  cfg_wdata;

  int   error_count;
  int   pending_count;

  // Shared between the stimulus and the output stall process.
  bit   allow_idle;
  bit   hold_off_req;

  // The stimulus keeps its own idea of how many steps the current line still owes, so that
  // it can tell which step words will be ignored and leave them out of the word count.
  int   line_left;
  int   words_sent;

  antialiased_line_rasterizer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  aalr_pixel_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall limit. The slowest correct run, with every word waiting out the longest stalls
  // on both sides, comes to well under a fifth of this.
  initial begin
    #10_000_000;
    $display("** antialiased_line_rasterizer_core: FAILED **");
    $finish;
  end

  // Output side. Each pass makes exactly one assignment to out_tready and then waits at
  // least one edge. A hold-off request from the stimulus takes priority, so that the block
  // fills up and drops in_tready while words are still on offer.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (allow_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offers one word and returns at the edge where it is taken, or after the idle burst that
  // may follow. in_tvalid stays high on the way out unless an idle burst follows, so
  // back-to-back words never drop and raise it in the same step.
  task automatic send_word(input logic op, input logic [COORD_BITS-1:0] sx,
                           input logic [COORD_BITS-1:0] sy, input logic [COORD_BITS-1:0] ex,
                           input logic [COORD_BITS-1:0] ey, input logic [COLOR_BITS-1:0] colour);
    in_tdata  <= IN_TDATA_W'({colour, ey, ex, sy, sx});
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Loads a new line; the endpoints are cut to the coordinate width, so any integer will do.
  task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_BITS-1:0] colour);
    int dx, dy;
    dx = int'($signed(COORD_BITS'(ex))) - int'($signed(COORD_BITS'(sx)));
    dy = int'($signed(COORD_BITS'(ey))) - int'($signed(COORD_BITS'(sy)));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    send_word(OP_START, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex), COORD_BITS'(ey),
              colour);
    // One step per major coordinate, both ends included.
    line_left = ((dx > dy) ? dx : dy) + 1;
    words_sent++;
  endtask

  // A step carries random data in its payload, which the block must ignore.
  task automatic step_once();
    send_word(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COLOR_BITS'($urandom));
    if (line_left > 0) begin
      line_left--;
      words_sent++;
    end
  endtask

  // Mostly short lines close to the frame, so that pixels fall on both sides of its edges,
  // with now and then a line anywhere in the coordinate range. Most lines are stepped to
  // their end; some are cut short and some get a step or two after they have finished.
  task automatic random_line(input int wwin, input int hwin);
    int sx, sy, ex, ey, reach, steps;
    if ($urandom_range(0, 7) == 0) begin
      sx = $urandom;
      sy = $urandom;
      ex = $urandom;
      ey = $urandom;
    end else begin
      reach = $urandom_range(0, 12);
      sx = $urandom_range(0, wwin + 16) - 8;
      sy = $urandom_range(0, hwin + 16) - 8;
      ex = sx + $urandom_range(0, 2 * reach) - reach;
      ey = sy + $urandom_range(0, 2 * reach) - reach;
    end
    start_line(sx, sy, ex, ey, COLOR_BITS'($urandom));
    steps = (line_left > MAX_STEPS) ? MAX_STEPS : line_left;
    case ($urandom_range(0, 9))
      0: begin
        steps = $urandom_range(0, steps - 1);
      end
      1: begin
        steps = steps + $urandom_range(1, 2);
      end
      default: begin
      end
    endcase
    repeat (steps) step_once();
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= FRAME_BITS'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering words and waits until every predicted pixel word has come out, then
  // gives a start word that produced nothing time to finish its slope division.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fw, fh, wwin, hwin, target;
    // Frame sizes per phase. The first phase keeps the reset size of 800 by 600. A size of
    // 4096 does not fit the 12-bit registers and reads back as zero, so nothing is in frame.
    // 4095 is the largest value the registers hold. The fifth phase picks its own size.
    int widths[PHASES]  = '{800, 1, 4096, 4095, 0, 2047};
    int heights[PHASES] = '{600, 1, 4096, 4095, 0, 1};

    allow_idle   = 1'b1;
    hold_off_req = 1'b0;
    line_left    = 0;
    words_sent   = 0;
    target       = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_START;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_FRAME_WIDTH;
    cfg_wdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A step before any line has been started must be ignored.
    step_once();
    // Single-point line: one step gives the pair at the point and ends the line, and the
    // step after it finds the block idle again.
    start_line(5, 5, 5, 5, 24'h000000);
    step_once();
    step_once();
    // Steep line given right to left: it is transposed and reordered. It is left unfinished
    // and the next start replaces it.
    start_line(10, 20, 8, 14, 24'hFFFFFF);
    repeat (2) step_once();
    // Corner to corner across the whole coordinate range, with a gradient of exactly one.
    start_line(-2048, -2048, 2047, 2047, 24'hABCDEF);
    repeat (2) step_once();
    // The other diagonal, with a gradient of exactly minus one.
    start_line(2047, -2048, -2048, 2047, 24'h123456);
    repeat (2) step_once();
    // Vertical line at the most negative column.
    start_line(-2048, 2047, -2048, -2048, 24'h654321);
    step_once();
    // Short shallow line with a fractional gradient, stepped through to its last pixel.
    start_line(0, 0, 3, 1, 24'h800000);
    repeat (4) step_once();

    for (int ph = 0; ph < PHASES; ph++) begin
      fw = widths[ph];
      fh = heights[ph];
      if (ph == 4) begin
        fw = $urandom_range(1, 2048);
        fh = $urandom_range(1, 2048);
      end
      if (ph > 0) begin
        settle();
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
      end
      // The last phase runs with both sides flat out.
      if (ph == PHASES - 1) allow_idle = 1'b0;
      wwin = (fw % 4096 == 0) ? 64 : fw;
      hwin = (fh % 4096 == 0) ? 64 : fh;
      if (ph == 0) begin
        // Back the block up: the output holds off while a long line is stepped.
        hold_off_req = 1'b1;
        start_line(0, 0, 15, 7, 24'h00FF00);
        repeat (16) step_once();
      end
      target += WORDS_PER_PHASE;
      while (words_sent < target) begin
        if (line_left == 0 && $urandom_range(0, 9) == 0) step_once();
        else random_line(wwin, hwin);
      end
    end

    settle();
    if (error_count == 0) begin
      $display("** antialiased_line_rasterizer_core: PASSED **");
    end else begin
      $display("** antialiased_line_rasterizer_core: FAILED **");
    end
    $finish;
  end

endmodule
